// ===== src/pausable_countdown_timer_core_defines.svh =====
// Assertion macros shared by the timer checker.
`ifndef PAUSABLE_COUNTDOWN_TIMER_CORE_DEFINES_SVH
`define PAUSABLE_COUNTDOWN_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pct_pkg.sv =====
// Types, codes and the duration conversion for the countdown timer.
package pct_pkg;

  // Command codes
  localparam logic [2:0] CMD_POLL    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_RESTART = 3'd2;
  localparam logic [2:0] CMD_PAUSE   = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;
  localparam logic [2:0] CMD_INIT    = 3'd5;

  // Timer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_PAUSE = 2'd2;
  localparam logic [1:0] ST_EXP   = 2'd3;

  // Time unit codes
  localparam logic [2:0] UNIT_US  = 3'd0;
  localparam logic [2:0] UNIT_MS  = 3'd1;
  localparam logic [2:0] UNIT_S   = 3'd2;
  localparam logic [2:0] UNIT_MIN = 3'd3;
  localparam logic [2:0] UNIT_H   = 3'd4;

  // Milliseconds per unit
  localparam int          SCALE_W      = 22;
  localparam logic [21:0] MS_PER_S     = 22'd1000;
  localparam logic [21:0] MS_PER_MIN   = 22'd60000;
  localparam logic [21:0] MS_PER_H     = 22'd3600000;
  localparam logic [31:0] TICK_MAX     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] duration_value;
    logic [2:0]  time_unit;
    logic        auto_restart;
    logic        tick_ms;
    logic        tick_us;
  } pct_in_t;

  typedef struct packed {
    logic [1:0]  timer_status;
    logic [31:0] time_left;
    logic        end_event;
  } pct_out_t;

  // Convert a duration to base ticks, saturating at the counter maximum.
  function automatic logic [31:0] pct_to_ticks(input logic [2:0] unit,
                                               input logic [31:0] value);
    logic [SCALE_W-1:0]    scale;
    logic [SCALE_W+31:0]   prod;
    begin
      case (unit)
        UNIT_S:   scale = MS_PER_S;
        UNIT_MIN: scale = MS_PER_MIN;
        UNIT_H:   scale = MS_PER_H;
        default:  scale = SCALE_W'(1);
      endcase
      prod = {{SCALE_W{1'b0}}, value} * {32'b0, scale};
      pct_to_ticks = (prod[SCALE_W+31:32] != '0) ? TICK_MAX : prod[31:0];
    end
  endfunction

endpackage

// ===== src/pausable_countdown_timer_core.sv =====
// Pausable countdown timer with auto-reload: one result beat per input beat.
// An accepted beat's result is registered in the output register, or in the
// skid if stalled. Throughput: one beat per cycle while in_stall is low; the
// saturating constant multiply, increment and compare are in the accept cycle.
// A two-entry output buffer (output register plus skid) keeps input open while
// one result waits. Synchronous active-low reset: idle, all counts zero.
module pausable_countdown_timer_core
  import pct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pct_out_t out_data
);

  // Timer state
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic        micro_r, micro_nxt;
  logic        reload_r, reload_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] paused_r, paused_nxt;

  // Output buffer
  logic        out_valid_r, out_valid_nxt;
  pct_out_t    out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  pct_out_t    skid_data_r, skid_data_nxt;

  logic        in_acc;
  logic        out_take;
  logic        tick;
  logic [31:0] elapsed_tk;
  logic [31:0] load_ticks;
  logic        load_micro;
  logic [31:0] run_left;
  pct_out_t    res;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  // Convert the offered duration
  assign load_ticks = pct_to_ticks(in_data.time_unit, in_data.duration_value);
  assign load_micro = (in_data.time_unit == UNIT_US);

  // Advance the elapsed count on a tick of the base unit
  assign tick       = micro_r ? in_data.tick_us : in_data.tick_ms;
  assign elapsed_tk = (mode_r == ST_RUN && tick && elapsed_r != TICK_MAX) ?
                      elapsed_r + 32'd1 : elapsed_r;

  // Apply the command, then the expiry check, then form the result
  always_comb begin
    mode_nxt    = mode_r;
    dur_nxt     = dur_r;
    micro_nxt   = micro_r;
    reload_nxt  = reload_r;
    elapsed_nxt = elapsed_tk;
    paused_nxt  = paused_r;
    res         = '0;

    case (in_data.command)
      CMD_START: begin
        if (mode_r != ST_RUN) begin
          if (in_data.duration_value != '0) begin
            dur_nxt     = load_ticks;
            micro_nxt   = load_micro;
            reload_nxt  = in_data.auto_restart;
            elapsed_nxt = '0;
          end else if (mode_r == ST_PAUSE) begin
            elapsed_nxt = (paused_r >= dur_r) ? '0 : dur_r - paused_r;
          end else begin
            elapsed_nxt = '0;
          end
          mode_nxt = ST_RUN;
        end
      end
      CMD_RESTART: begin
        elapsed_nxt = '0;
        mode_nxt    = ST_RUN;
      end
      CMD_PAUSE: begin
        if (mode_r == ST_RUN) begin
          paused_nxt = (elapsed_tk >= dur_r) ? '0 : dur_r - elapsed_tk;
          mode_nxt   = ST_PAUSE;
        end
      end
      CMD_STOP: begin
        mode_nxt    = ST_IDLE;
        elapsed_nxt = '0;
        paused_nxt  = '0;
      end
      CMD_INIT: begin
        dur_nxt    = load_ticks;
        micro_nxt  = load_micro;
        reload_nxt = in_data.auto_restart;
        mode_nxt   = ST_IDLE;
      end
      default: begin
      end
    endcase

    // Expire once the elapsed count reaches the duration, or reload if enabled
    if (mode_nxt == ST_RUN && elapsed_nxt >= dur_nxt) begin
      res.end_event = 1'b1;
      if (reload_nxt) begin
        elapsed_nxt = '0;
      end else begin
        mode_nxt = ST_EXP;
      end
    end

    run_left = (elapsed_nxt >= dur_nxt) ? '0 : dur_nxt - elapsed_nxt;
    res.timer_status = mode_nxt;
    case (mode_nxt)
      ST_RUN:   res.time_left = run_left;
      ST_PAUSE: res.time_left = paused_nxt;
      ST_EXP:   res.time_left = '0;
      default:  res.time_left = dur_nxt;
    endcase
  end

  // Route the result into the output register or the skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_take) begin
      out_valid_nxt  = skid_valid_r || in_acc;
      out_data_nxt   = skid_valid_r ? skid_data_r : res;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  // Hold control state, clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= ST_IDLE;
      dur_r        <= '0;
      micro_r      <= 1'b0;
      reload_r     <= 1'b0;
      elapsed_r    <= '0;
      paused_r     <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_r    <= mode_nxt;
        dur_r     <= dur_nxt;
        micro_r   <= micro_nxt;
        reload_r  <= reload_nxt;
        elapsed_r <= elapsed_nxt;
        paused_r  <= paused_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/pct_checker.sv =====
// Port-level checks for the countdown timer, bound to the top level.
`include "pausable_countdown_timer_core_defines.svh"

module pct_checker
  import pct_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input pct_out_t out_data
);

  // An end pulse only comes with a running or expired timer
  `PCT_ASSERT_SAME(a_end_state, out_valid && out_data.end_event, out_data.timer_status == ST_RUN || out_data.timer_status == ST_EXP, "end beat with idle or paused status")

  // An expired timer shows no time left
  `PCT_ASSERT_SAME(a_exp_zero, out_valid && out_data.timer_status == ST_EXP, out_data.time_left == '0, "expired beat with time left")

  // Input stalls only while a result is waiting
  `PCT_ASSERT_SAME(a_stall_out, in_stall, out_valid, "input stalled with empty output")

  // A stalled result beat stays and holds its payload
  `PCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind pausable_countdown_timer_core pct_checker u_pct_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the pausable countdown timer core.
module tb
  import pct_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the defined ranges; the core must treat them as poll / ms base
  localparam logic [2:0] CMD_RSVD_LO  = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI  = 3'd7;
  localparam logic [2:0] UNIT_RSVD_LO = 3'd5;
  localparam logic [2:0] UNIT_RSVD_HI = 3'd7;
  localparam int         CYCLE_LIMIT  = 100000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pct_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pct_out_t out_data;

  // Set during the burst phase: neither side inserts bubbles
  logic     no_gaps = 1'b0;

  pct_out_t pending_results[$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       results_checked = 0;
  int       expiries = 0;
  int       cycle_count = 0;

  // Timer state mirrored on the bench side
  logic [1:0]  t_mode = ST_IDLE;
  logic [31:0] t_duration = '0;
  logic        t_micro = 1'b0;
  logic        t_reload = 1'b0;
  logic [31:0] t_elapsed = '0;
  logic [31:0] t_paused = '0;

  pausable_countdown_timer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Convert a duration to base ticks, clamping at the counter maximum
  function automatic logic [31:0] ticks_for(logic [2:0] unit, logic [31:0] value);
    logic [63:0] scale;
    logic [63:0] scaled;
    case (unit)
      UNIT_S:   scale = 64'(MS_PER_S);
      UNIT_MIN: scale = 64'(MS_PER_MIN);
      UNIT_H:   scale = 64'(MS_PER_H);
      default:  scale = 64'd1;
    endcase
    scaled = {32'b0, value} * scale;
    return (scaled > {32'b0, TICK_MAX}) ? TICK_MAX : scaled[31:0];
  endfunction

  function automatic logic [31:0] run_left();
    return (t_elapsed >= t_duration) ? 32'd0 : t_duration - t_elapsed;
  endfunction

  function automatic void load_timer(pct_in_t b);
    t_duration = ticks_for(b.time_unit, b.duration_value);
    t_micro    = (b.time_unit == UNIT_US);
    t_reload   = b.auto_restart;
    t_mode     = ST_IDLE;
  endfunction

  // Advance the mirrored timer by one input beat and form its result
  function automatic pct_out_t timer_next(pct_in_t b);
    logic     tick;
    logic     resume;
    pct_out_t r;
    r = '0;
    tick = t_micro ? b.tick_us : b.tick_ms;
    if (t_mode == ST_RUN && tick && t_elapsed != TICK_MAX) t_elapsed = t_elapsed + 32'd1;

    case (b.command)
      CMD_START: begin
        if (t_mode != ST_RUN) begin
          resume = (t_mode == ST_PAUSE);
          if (b.duration_value != '0) begin
            load_timer(b);
            resume = 1'b0;
          end
          if (resume)
            t_elapsed = (t_paused >= t_duration) ? 32'd0 : t_duration - t_paused;
          else
            t_elapsed = '0;
          t_mode = ST_RUN;
        end
      end
      CMD_RESTART: begin
        t_elapsed = '0;
        t_mode = ST_RUN;
      end
      CMD_PAUSE: begin
        if (t_mode == ST_RUN) begin
          t_paused = run_left();
          t_mode = ST_PAUSE;
        end
      end
      CMD_STOP: begin
        t_mode = ST_IDLE;
        t_elapsed = '0;
        t_paused = '0;
      end
      CMD_INIT: load_timer(b);
      default: ;
    endcase

    // Expiry check, then reload if enabled
    if (t_mode == ST_RUN && t_elapsed >= t_duration) begin
      t_mode = ST_EXP;
      r.end_event = 1'b1;
      if (t_reload) begin
        t_elapsed = '0;
        t_mode = ST_RUN;
      end
    end

    case (t_mode)
      ST_RUN:   r.time_left = run_left();
      ST_PAUSE: r.time_left = t_paused;
      ST_EXP:   r.time_left = '0;
      default:  r.time_left = t_duration;
    endcase
    r.timer_status = t_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    pct_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(out_data), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.timer_status !== want.timer_status)
          report_mismatch("timer_status", 32'(out_data.timer_status),
                          32'(want.timer_status));
        if (out_data.time_left !== want.time_left)
          report_mismatch("time_left", out_data.time_left, want.time_left);
        if (out_data.end_event !== want.end_event)
          report_mismatch("end_event", 32'(out_data.end_event), 32'(want.end_event));
        results_checked++;
        if (want.end_event) expiries++;
      end
    end
  end

  // Random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 20);
  end

  // ---------------------------------------------------------------- stimulus

  function automatic pct_in_t mk(logic [2:0] cmd, logic [31:0] value, logic [2:0] unit,
                                 logic ar, logic tms, logic tus);
    pct_in_t b;
    b.command        = cmd;
    b.duration_value = value;
    b.time_unit      = unit;
    b.auto_restart   = ar;
    b.tick_ms        = tms;
    b.tick_us        = tus;
    return b;
  endfunction

  // Drive one beat, hold it until accepted, then record its expected result
  task automatic send_beat(pct_in_t b);
    if (!no_gaps && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(timer_next(b));
    beats_sent++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 75) return 32'($urandom_range(1, 15));
    if (r < 82) return TICK_MAX;
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_unit();
    int r;
    r = $urandom_range(99);
    if (r < 45) return UNIT_US;
    if (r < 80) return UNIT_MS;
    return 3'($urandom_range(7));
  endfunction

  function automatic pct_in_t noise_beat();
    return mk(3'($urandom_range(7)), $urandom(), 3'($urandom_range(7)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // Mostly polls with ticks, mixed with the other commands and some noise
  function automatic pct_in_t pick_followup();
    int          r;
    logic [2:0]  cmd;
    logic [31:0] value;
    r = $urandom_range(99);
    value = '0;
    if (r < 60)      cmd = CMD_POLL;
    else if (r < 68) cmd = CMD_PAUSE;
    else if (r < 78) begin
      cmd = CMD_START;
      if ($urandom_range(99) < 20) value = pick_duration();
    end
    else if (r < 84) cmd = CMD_RESTART;
    else if (r < 89) cmd = CMD_STOP;
    else if (r < 93) begin
      cmd = CMD_INIT;
      value = pick_duration();
    end
    else if (r < 96) cmd = $urandom_range(1) ? CMD_RSVD_LO : CMD_RSVD_HI;
    else return noise_beat();
    return mk(cmd, value, pick_unit(), 1'($urandom_range(1)),
              $urandom_range(99) < 70, $urandom_range(99) < 70);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    // Reset state, then saturating and full-range conversions
    send_beat(mk(CMD_POLL, '0, UNIT_MS, 1'b0, 1'b1, 1'b1));
    send_beat(mk(CMD_INIT, TICK_MAX, UNIT_H, 1'b1, 1'b0, 1'b0));
    send_beat(mk(CMD_INIT, TICK_MAX, UNIT_MIN, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_INIT, TICK_MAX, UNIT_US, 1'b0, 1'b0, 1'b0));
    // Three microsecond ticks, one-shot; start with zero keeps the settings
    send_beat(mk(CMD_INIT, 32'd3, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_START, '0, UNIT_MS, 1'b1, 1'b0, 1'b0));
    // Start while running is ignored; ms tick ignored in us base
    send_beat(mk(CMD_START, 32'd5, UNIT_S, 1'b1, 1'b0, 1'b1));
    send_beat(mk(CMD_POLL, '0, UNIT_US, 1'b0, 1'b1, 1'b0));
    // Pause, pause again while paused, resume, expire
    send_beat(mk(CMD_PAUSE, '0, UNIT_US, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_PAUSE, '0, UNIT_US, 1'b0, 1'b1, 1'b1));
    send_beat(mk(CMD_START, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_POLL, '0, UNIT_US, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_POLL, '0, UNIT_US, 1'b0, 1'b1, 1'b1));
    // Pause on the last tick leaves nothing; resume then expires at once
    send_beat(mk(CMD_START, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_POLL, '0, UNIT_US, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_POLL, '0, UNIT_US, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_PAUSE, '0, UNIT_US, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_START, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    // Restart from expired and from paused, then stop
    send_beat(mk(CMD_RESTART, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_PAUSE, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_RESTART, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    send_beat(mk(CMD_STOP, '0, UNIT_US, 1'b0, 1'b0, 1'b0));
    // Zero duration with reload fires on every beat while running
    send_beat(mk(CMD_INIT, '0, UNIT_MS, 1'b1, 1'b0, 1'b0));
    send_beat(mk(CMD_RESTART, '0, UNIT_MS, 1'b0, 1'b1, 1'b0));
    send_beat(mk(CMD_PAUSE, '0, UNIT_MS, 1'b0, 1'b1, 1'b0));
    // New duration while paused restarts fresh; undefined unit and command codes
    send_beat(mk(CMD_START, 32'd2, UNIT_RSVD_LO, 1'b0, 1'b0, 1'b1));
    send_beat(mk(CMD_RSVD_HI, TICK_MAX, UNIT_RSVD_HI, 1'b1, 1'b1, 1'b1));
    send_beat(mk(CMD_RSVD_LO, '0, UNIT_US, 1'b0, 1'b1, 1'b0));
  endtask

  // Setup beat(s) followed by a run of polls and commands with random ticks
  task automatic test_timer_sequences(int n_beats);
    int         sent;
    int         len;
    logic [2:0] unit;
    logic       ar;
    sent = 0;
    while (sent < n_beats) begin
      unit = pick_unit();
      ar = 1'($urandom_range(1));
      if ($urandom_range(1)) begin
        send_beat(mk(CMD_INIT, pick_duration(), unit, ar, 1'b0, 1'b0));
        send_beat(mk(CMD_START, '0, unit, ar, 1'($urandom_range(1)),
                     1'($urandom_range(1))));
        sent += 2;
      end else begin
        send_beat(mk(CMD_START, pick_duration(), unit, ar, 1'b0, 1'b0));
        sent++;
      end
      len = $urandom_range(4, 30);
      repeat (len) send_beat(pick_followup());
      sent += len;
    end
  endtask

  // Drain first, then push beats with no bubbles on either side
  task automatic test_back_to_back(int n_beats);
    wait_drained();
    no_gaps <= 1'b1;
    test_timer_sequences(n_beats);
    no_gaps <= 1'b0;
  endtask

  task automatic test_random_noise(int n_beats);
    repeat (n_beats) send_beat(noise_beat());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_timer_sequences(250);
    test_back_to_back(120);
    test_random_noise(100);
    wait_drained();

    $display("Sent %0d input beats, checked %0d result beats, %0d expiry pulses.",
             beats_sent, results_checked, expiries);
    $display("Covered all commands and units, pause/resume, reload and reserved codes.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
